>>> design/mmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types and constants for the bank-switching mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package mmc_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int PRG_CNT_W   = 9;
    localparam int CHR_CNT_W   = 11;
    localparam int BANK_W      = 8;
    localparam int NUM_BANKS   = 8;
    localparam int MEM_ADDR_W  = 22;
    localparam int REM_STEPS   = BANK_W;
    localparam int REM_CNT_W   = $clog2(REM_STEPS);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANKS = 1'b1;

    localparam logic [PRG_CNT_W-1:0] PRG_BANKS_RST = 9'd2;
    localparam logic [CHR_CNT_W-1:0] CHR_BANKS_RST = 11'd8;

    typedef enum logic [2:0] {
        ACT_CPU_RD = 3'd0,
        ACT_CPU_WR = 3'd1,
        ACT_PPU_RD = 3'd2,
        ACT_PPU_WR = 3'd3,
        ACT_TICK   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        TGT_NONE       = 3'd0,
        TGT_PRG_RD     = 3'd1,
        TGT_CHR_RD     = 3'd2,
        TGT_CHR_RAM_RD = 3'd3,
        TGT_CHR_RAM_WR = 3'd4
    } t_target;

    // CPU register windows, address bits 14:13 above 0x8000
    typedef enum logic [1:0] {
        WIN_8000 = 2'd0,
        WIN_A000 = 2'd1,
        WIN_C000 = 2'd2,
        WIN_E000 = 2'd3
    } t_window;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            mem_target;
        logic [MEM_ADDR_W-1:0] mem_address;
        logic [7:0]            mem_write_data;
        logic                  irq_pending;
        logic                  mirror_horizontal;
    } t_out_item;

    // Mapper state as seen by the address path
    typedef struct packed {
        logic [BANK_W-1:0]                bank_select;
        logic [NUM_BANKS-1:0][BANK_W-1:0] bank_reg;
        logic                             irq_flag;
        logic                             mirror_h;
        logic [PRG_CNT_W-1:0]             prg_banks;
        logic [CHR_CNT_W-1:0]             chr_banks;
    } t_map_view;

    typedef struct packed {
        logic                 start;
        logic [BANK_W-1:0]    dividend;
        logic [CHR_CNT_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [CHR_CNT_W-1:0] rem;
    } t_rem_rsp;

endpackage

>>> design/mmc_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_state
// Mapper register file: bank select, bank registers, mirroring, IRQ counter
// and the bank-count configuration registers.
// ----------------------------------------------------------------------------
module mmc_state (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mmc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_commit,
    input  mmc_pkg::t_in_item                  i_item,
    output mmc_pkg::t_map_view                 o_view
);
    import mmc_pkg::*;

    logic [BANK_W-1:0]                r_bank_select;
    logic [NUM_BANKS-1:0][BANK_W-1:0] r_bank_reg;
    logic [7:0]                       r_irq_reload;
    logic [7:0]                       r_irq_count;
    logic                             r_irq_en;
    logic                             r_irq_flag;
    logic                             r_mirror_h;
    logic [PRG_CNT_W-1:0]             r_prg_banks;
    logic [CHR_CNT_W-1:0]             r_chr_banks;

    logic [7:0] n_irq_count;
    logic       odd;

    assign odd = i_item.address[0];

    always_comb begin
        if (r_irq_count == 8'd0) begin
            n_irq_count = r_irq_reload;
        end else begin
            n_irq_count = r_irq_count - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= '0;
            r_bank_reg    <= '0;
            r_irq_reload  <= '0;
            r_irq_count   <= '0;
            r_irq_en      <= 1'b0;
            r_irq_flag    <= 1'b0;
            r_mirror_h    <= 1'b1;
            r_prg_banks   <= PRG_BANKS_RST;
            r_chr_banks   <= CHR_BANKS_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRG_BANKS: r_prg_banks <= i_cfg_data[PRG_CNT_W-1:0];
                    CFG_CHR_BANKS: r_chr_banks <= i_cfg_data[CHR_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_commit) begin
                case (t_action'(i_item.action))
                    ACT_CPU_WR: begin
                        if (i_item.address[15]) begin
                            case (t_window'(i_item.address[14:13]))
                                WIN_8000: begin
                                    if (odd) begin
                                        r_bank_reg[r_bank_select[2:0]] <= i_item.write_data;
                                    end else begin
                                        r_bank_select <= i_item.write_data;
                                    end
                                end
                                WIN_A000: begin
                                    if (!odd) begin
                                        r_mirror_h <= i_item.write_data[0];
                                    end
                                end
                                WIN_C000: begin
                                    if (odd) begin
                                        r_irq_count <= '0;
                                    end else begin
                                        r_irq_reload <= i_item.write_data;
                                    end
                                end
                                WIN_E000: begin
                                    r_irq_en <= odd;
                                    if (!odd) begin
                                        r_irq_flag <= 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    ACT_TICK: begin
                        r_irq_count <= n_irq_count;
                        if (n_irq_count == 8'd0 && r_irq_en) begin
                            r_irq_flag <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_view.bank_select = r_bank_select;
        o_view.bank_reg    = r_bank_reg;
        o_view.irq_flag    = r_irq_flag;
        o_view.mirror_h    = r_mirror_h;
        o_view.prg_banks   = r_prg_banks;
        o_view.chr_banks   = r_chr_banks;
    end

endmodule

>>> design/mmc_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_rem
// Bit-serial restoring remainder: bank number modulo bank count, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module mmc_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmc_pkg::t_rem_req i_req,
    output mmc_pkg::t_rem_rsp o_rsp
);
    import mmc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [BANK_W-1:0]    r_dvd;
    logic [CHR_CNT_W-1:0] r_div;
    logic [CHR_CNT_W-1:0] r_rem;

    logic [CHR_CNT_W:0]   trial;
    logic [CHR_CNT_W:0]   diff;
    logic [CHR_CNT_W-1:0] n_rem;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    assign trial = {r_rem, r_dvd[BANK_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign n_rem = (trial >= {1'b0, r_div}) ? diff[CHR_CNT_W-1:0] : trial[CHR_CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == REM_CNT_W'(REM_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[BANK_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        o_rsp.rem  = r_rem;
    end

endmodule

>>> design/bank_switch_mapper_scanline_irq_unit.sv
`timescale 1ns / 1ps
// A PRG read through R6/R7 or a CHR ROM read goes through the bit-serial remainder
// unit (one bank-number bit per cycle) between decode and the result load; every other
// item goes straight from decode to the result register. One item in flight: the input
// is stalled until the result of the last item has been loaded.
// Reset (synchronous, active low) clears the mapper state, sets horizontal
// mirroring and loads bank counts of 2 (PRG) and 8 (CHR); it needs no clearing pass.
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_unit
// Bank-switching mapper: CPU/PPU address translation and scanline IRQ counter.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mmc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mmc_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mmc_pkg::t_out_item              o_out_item
);
    import mmc_pkg::*;

    t_state    r_state, n_state;
    t_in_item  r_item;
    t_map_view view;
    t_rem_req  rem_req;
    t_rem_rsp  rem_rsp;

    logic                  r_out_valid;
    t_out_item             r_out_item;
    logic [2:0]            r_target;
    logic [MEM_ADDR_W-1:0] r_addr;
    logic [7:0]            r_data;
    logic                  r_use_rem;
    logic                  r_rem_chr;

    logic in_fire, out_fire, out_free;
    logic commit, rem_start, out_load;

    // per-item decode
    t_target               x_target;
    logic [MEM_ADDR_W-1:0] x_addr;
    logic [7:0]            x_data;
    logic                  x_use_rem;
    logic                  x_rem_chr;
    logic [BANK_W-1:0]     x_dividend;
    logic [CHR_CNT_W-1:0]  x_divisor;

    logic [PRG_CNT_W-1:0]  prg_n, prg_second_last, prg_last, prg_direct;
    logic                  prg_swap;
    logic [15:0]           chr_a;
    logic [2:0]            chr_slot;
    logic [BANK_W-1:0]     chr_bank;
    logic [MEM_ADDR_W-1:0] fin_addr;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    mmc_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_commit    (commit),
        .i_item      (r_item),
        .o_view      (view)
    );

    mmc_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    // PRG fixed banks; a count of zero acts as one
    always_comb begin
        prg_n = (view.prg_banks == '0) ? PRG_CNT_W'(1) : view.prg_banks;
        prg_second_last = (prg_n >= PRG_CNT_W'(2)) ? prg_n - PRG_CNT_W'(2) : '0;
        prg_last = prg_n - PRG_CNT_W'(1);
        prg_swap = view.bank_select[6];
    end

    // CHR slot after the 4K half swap
    always_comb begin
        chr_a    = r_item.address ^ {3'b000, view.bank_select[7], 12'h000};
        chr_slot = chr_a[12:10];
        case (chr_slot)
            3'd0:    chr_bank = {view.bank_reg[0][7:1], 1'b0};
            3'd1:    chr_bank = {view.bank_reg[0][7:1], 1'b1};
            3'd2:    chr_bank = {view.bank_reg[1][7:1], 1'b0};
            3'd3:    chr_bank = {view.bank_reg[1][7:1], 1'b1};
            default: chr_bank = view.bank_reg[chr_slot - 3'd2];
        endcase
    end

    always_comb begin
        x_target   = TGT_NONE;
        x_addr     = '0;
        x_data     = '0;
        x_use_rem  = 1'b0;
        x_rem_chr  = 1'b0;
        x_dividend = '0;
        x_divisor  = CHR_CNT_W'(prg_n);
        prg_direct = prg_last;
        case (t_action'(r_item.action))
            ACT_CPU_RD: begin
                if (r_item.address[15]) begin
                    x_target = TGT_PRG_RD;
                    case (t_window'(r_item.address[14:13]))
                        WIN_8000: begin
                            x_use_rem  = !prg_swap;
                            x_dividend = view.bank_reg[6];
                            prg_direct = prg_second_last;
                        end
                        WIN_A000: begin
                            x_use_rem  = 1'b1;
                            x_dividend = view.bank_reg[7];
                        end
                        WIN_C000: begin
                            x_use_rem  = prg_swap;
                            x_dividend = view.bank_reg[6];
                            prg_direct = prg_second_last;
                        end
                        default: prg_direct = prg_last;
                    endcase
                    x_addr = {prg_direct, r_item.address[12:0]};
                end
            end
            ACT_PPU_RD: begin
                if (r_item.address[15:13] == 3'b000) begin
                    if (view.chr_banks == '0) begin
                        x_target = TGT_CHR_RAM_RD;
                        x_addr   = MEM_ADDR_W'(r_item.address);
                    end else begin
                        x_target   = TGT_CHR_RD;
                        x_use_rem  = 1'b1;
                        x_rem_chr  = 1'b1;
                        x_dividend = chr_bank;
                        x_divisor  = view.chr_banks;
                    end
                end
            end
            ACT_PPU_WR: begin
                if (r_item.address[15:13] == 3'b000 && view.chr_banks == '0) begin
                    x_target = TGT_CHR_RAM_WR;
                    x_addr   = MEM_ADDR_W'(r_item.address);
                    x_data   = r_item.write_data;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_EXEC;
            ST_EXEC:  n_state = x_use_rem ? ST_DIV : ST_WRITE;
            ST_DIV:   if (rem_rsp.done) n_state = ST_WRITE;
            ST_WRITE: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        commit     = 1'b0;
        rem_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_EXEC: begin
                commit    = 1'b1;
                rem_start = x_use_rem;
            end
            ST_WRITE: out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        rem_req.start    = rem_start;
        rem_req.dividend = x_dividend;
        rem_req.divisor  = x_divisor;
    end

    always_comb begin
        if (!r_use_rem) begin
            fin_addr = r_addr;
        end else if (r_rem_chr) begin
            fin_addr = MEM_ADDR_W'({rem_rsp.rem, r_item.address[9:0]});
        end else begin
            fin_addr = {rem_rsp.rem[PRG_CNT_W-1:0], r_item.address[12:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_item;
        end
        if (r_state == ST_EXEC) begin
            r_target  <= x_target;
            r_addr    <= x_addr;
            r_data    <= x_data;
            r_use_rem <= x_use_rem;
            r_rem_chr <= x_rem_chr;
        end
        if (out_load) begin
            r_out_item.mem_target        <= r_target;
            r_out_item.mem_address       <= fin_addr;
            r_out_item.mem_write_data    <= r_data;
            r_out_item.irq_pending       <= view.irq_flag;
            r_out_item.mirror_horizontal <= view.mirror_h;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an undelivered transfer");

    a_div_unit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (rem_rsp.busy || rem_rsp.done))
        else $error("waiting on remainder unit that is not running");

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> !rem_rsp.busy)
        else $error("remainder unit restarted while busy");

    a_return_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == ST_IDLE && r_out_valid))
        else $error("sequencer did not return to idle after result load");

    a_none_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_target == TGT_NONE) |=> (o_out_item.mem_address == '0))
        else $error("address set on an item with no memory target");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bank-switching mapper: a queue-fed driver and a
// monitor check every transfer against a local mapper model over several bank
// count settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import mmc_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;

    bank_switch_mapper_scanline_irq_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Mapper model state
    logic [PRG_CNT_W-1:0] prg_count = PRG_BANKS_RST;
    logic [CHR_CNT_W-1:0] chr_count = CHR_BANKS_RST;
    logic [7:0]           sel_reg = '0;
    logic [7:0]           bank_r [NUM_BANKS];
    logic [7:0]           irq_latch = '0;
    logic [7:0]           irq_ctr = '0;
    logic                 irq_en = 1'b0;
    logic                 irq_pend = 1'b0;
    logic                 mirror_h = 1'b1;

    t_in_item  bus_ops_q [$];
    t_out_item mapped_q [$];
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        n_fail = 0;

    initial begin
        foreach (bank_r[i]) bank_r[i] = '0;
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [MEM_ADDR_W-1:0] prg_phys(input logic [15:0] a);
        int unsigned n, second_last, last_bank, bank;
        n = (prg_count != 0) ? prg_count : 1;
        second_last = (2 * n - 2) % n;
        last_bank = n - 1;
        case (t_window'(a[14:13]))
            WIN_8000: bank = sel_reg[6] ? second_last : bank_r[6];
            WIN_A000: bank = bank_r[7];
            WIN_C000: bank = sel_reg[6] ? bank_r[6] : second_last;
            default:  bank = last_bank;
        endcase
        return MEM_ADDR_W'((bank % n) * 32'h2000 + a[12:0]);
    endfunction

    function automatic logic [MEM_ADDR_W-1:0] chr_phys(input logic [15:0] a);
        logic [15:0] s;
        int unsigned bank;
        s = a;
        if (sel_reg[7]) s[12] = ~s[12];   // swap the 4K halves
        case (s[12:10])
            3'd0:    bank = bank_r[0] & 8'hFE;
            3'd1:    bank = bank_r[0] | 8'h01;
            3'd2:    bank = bank_r[1] & 8'hFE;
            3'd3:    bank = bank_r[1] | 8'h01;
            default: bank = bank_r[s[12:10] - 3'd2];
        endcase
        return MEM_ADDR_W'((bank % chr_count) * 32'h400 + a[9:0]);
    endfunction

    function automatic void cpu_store(input logic [15:0] a, input logic [7:0] d);
        if (!a[15]) return;
        case (t_window'(a[14:13]))
            WIN_8000: begin
                if (a[0]) bank_r[sel_reg[2:0]] = d;
                else sel_reg = d;
            end
            WIN_A000: begin
                if (!a[0]) mirror_h = d[0];
            end
            WIN_C000: begin
                if (a[0]) irq_ctr = '0;
                else irq_latch = d;
            end
            default: begin
                irq_en = a[0];
                if (!a[0]) irq_pend = 1'b0;
            end
        endcase
    endfunction

    // Applies one bus operation to the model and returns the mapped access
    function automatic t_out_item map_access(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.action)
            ACT_CPU_RD: begin
                if (it.address[15]) begin
                    r.mem_target = TGT_PRG_RD;
                    r.mem_address = prg_phys(it.address);
                end
            end
            ACT_CPU_WR: cpu_store(it.address, it.write_data);
            ACT_PPU_RD: begin
                if (it.address < 16'h2000) begin
                    if (chr_count == 0) begin
                        r.mem_target = TGT_CHR_RAM_RD;
                        r.mem_address = MEM_ADDR_W'(it.address);
                    end else begin
                        r.mem_target = TGT_CHR_RD;
                        r.mem_address = chr_phys(it.address);
                    end
                end
            end
            ACT_PPU_WR: begin
                if (it.address < 16'h2000 && chr_count == 0) begin
                    r.mem_target = TGT_CHR_RAM_WR;
                    r.mem_address = MEM_ADDR_W'(it.address);
                    r.mem_write_data = it.write_data;
                end
            end
            ACT_TICK: begin
                if (irq_ctr == 0) irq_ctr = irq_latch;
                else irq_ctr = irq_ctr - 8'd1;
                if (irq_ctr == 0 && irq_en) irq_pend = 1'b1;
            end
            default: ;
        endcase
        r.irq_pending = irq_pend;
        r.mirror_horizontal = mirror_h;
        return r;
    endfunction

    // Driver: a transfer happens when valid is high and stall is low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) mapped_q.push_back(map_access(in_item));
            if (bus_ops_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item <= bus_ops_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (mapped_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_fail++;
                end else begin
                    want = mapped_q.pop_front();
                    if (out_item.mem_target !== want.mem_target) begin
                        $error("mem_target: expected %0d, got %0d",
                               want.mem_target, out_item.mem_target);
                        n_fail++;
                    end
                    if (out_item.mem_address !== want.mem_address) begin
                        $error("mem_address: expected 0x%06h, got 0x%06h",
                               want.mem_address, out_item.mem_address);
                        n_fail++;
                    end
                    if (out_item.mem_write_data !== want.mem_write_data) begin
                        $error("mem_write_data: expected 0x%02h, got 0x%02h",
                               want.mem_write_data, out_item.mem_write_data);
                        n_fail++;
                    end
                    if (out_item.irq_pending !== want.irq_pending) begin
                        $error("irq_pending: expected %0b, got %0b",
                               want.irq_pending, out_item.irq_pending);
                        n_fail++;
                    end
                    if (out_item.mirror_horizontal !== want.mirror_horizontal) begin
                        $error("mirror_horizontal: expected %0b, got %0b",
                               want.mirror_horizontal, out_item.mirror_horizontal);
                        n_fail++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic add_op(input t_action act, input logic [15:0] a, input logic [7:0] d);
        t_in_item it;
        it.action = act;
        it.address = a;
        it.write_data = d;
        bus_ops_q.push_back(it);
    endtask

    function automatic logic [15:0] reg_addr(input t_window w, input logic odd);
        logic [11:0] mid;
        mid = 12'($urandom);
        return {1'b1, w, mid, odd};
    endfunction

    function automatic logic [15:0] prg_rd_addr();
        return ($urandom_range(9) == 0) ? 16'($urandom) : {1'b1, 15'($urandom)};
    endfunction

    function automatic logic [15:0] chr_addr();
        return ($urandom_range(9) == 0) ? 16'($urandom) : {3'b000, 13'($urandom)};
    endfunction

    task automatic gen_traffic(input int n_ops);
        int stop_at, pick, k;
        logic [7:0] d;
        stop_at = bus_ops_q.size() + n_ops;
        while (bus_ops_q.size() < stop_at) begin
            pick = $urandom_range(99);
            d = 8'($urandom);
            if (pick < 20) begin
                // bank select then bank data, followed by a few reads
                add_op(ACT_CPU_WR, reg_addr(WIN_8000, 1'b0), d);
                add_op(ACT_CPU_WR, reg_addr(WIN_8000, 1'b1), 8'($urandom));
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(1)) add_op(ACT_CPU_RD, prg_rd_addr(), 8'($urandom));
                    else add_op(ACT_PPU_RD, chr_addr(), 8'($urandom));
                end
            end else if (pick < 35) begin
                // scanline counter: latch, reload, enable, ticks, maybe acknowledge
                add_op(ACT_CPU_WR, reg_addr(WIN_C000, 1'b0), 8'($urandom_range(0, 5)));
                add_op(ACT_CPU_WR, reg_addr(WIN_C000, 1'b1), d);
                add_op(ACT_CPU_WR, reg_addr(WIN_E000, $urandom_range(4) != 0),
                       8'($urandom));
                k = $urandom_range(1, 8);
                repeat (k) begin
                    add_op(ACT_TICK, 16'($urandom), 8'($urandom));
                    if ($urandom_range(3) == 0) add_op(ACT_PPU_RD, chr_addr(), d);
                end
                if ($urandom_range(1)) add_op(ACT_CPU_WR, reg_addr(WIN_E000, 1'b0), d);
            end else if (pick < 50) begin
                add_op(ACT_CPU_RD, prg_rd_addr(), d);
            end else if (pick < 70) begin
                add_op(ACT_PPU_RD, chr_addr(), d);
            end else if (pick < 78) begin
                add_op(ACT_PPU_WR, chr_addr(), d);
            end else if (pick < 85) begin
                add_op(ACT_CPU_WR, 16'($urandom), d);
            end else if (pick < 92) begin
                add_op(ACT_TICK, 16'($urandom), d);
            end else if (pick < 96) begin
                add_op(ACT_CPU_WR, reg_addr(WIN_A000, 1'($urandom)), d);
            end else begin
                // undefined action codes above the tick
                add_op(t_action'(ACT_TICK + 3'($urandom_range(1, 3))), 16'($urandom), d);
            end
        end
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        if (idx == CFG_PRG_BANKS) prg_count = PRG_CNT_W'(val);
        else chr_count = CHR_CNT_W'(val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (bus_ops_q.size() != 0 || in_valid || mapped_q.size() != 0);
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct = (mode == 1) ? 87 : (mode == 3) ? 12 : 0;
        stall_pct     = (mode == 2) ? 87 : (mode == 3) ? 12 : 0;
    endtask

    task automatic run_phase(input int unsigned prg, input int unsigned chr,
                             input int mode, input int n_ops);
        wait_drained();
        write_cfg(CFG_PRG_BANKS, prg);
        write_cfg(CFG_CHR_BANKS, chr);
        @(negedge i_clk);
        set_idling(mode);
        if (chr == 0) begin
            add_op(ACT_PPU_WR, 16'h0000, 8'hFF);
            add_op(ACT_PPU_WR, 16'h1FFF, 8'h00);
            add_op(ACT_PPU_RD, 16'h0000, 8'h00);
            add_op(ACT_PPU_RD, 16'h1FFF, 8'hFF);
            add_op(ACT_PPU_WR, 16'h2000, 8'h5A);
            add_op(ACT_PPU_RD, 16'hFFFF, 8'h00);
        end
        gen_traffic(n_ops);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset bank counts
        set_idling(0);
        add_op(ACT_CPU_RD, 16'h0000, 8'h00);
        add_op(ACT_CPU_RD, 16'h7FFF, 8'hFF);
        add_op(ACT_CPU_RD, 16'h8000, 8'h00);
        add_op(ACT_CPU_RD, 16'hFFFF, 8'h00);
        add_op(ACT_PPU_RD, 16'h0000, 8'h00);
        add_op(ACT_PPU_RD, 16'h1FFF, 8'h00);
        add_op(ACT_PPU_RD, 16'h2000, 8'h00);
        add_op(ACT_PPU_WR, 16'h0400, 8'hA5);    // CHR ROM: dropped
        add_op(ACT_CPU_WR, 16'h8000, 8'hC6);    // PRG swap, CHR inversion, R6
        add_op(ACT_CPU_WR, 16'h8001, 8'hFF);
        add_op(ACT_CPU_WR, 16'h8000, 8'hC7);
        add_op(ACT_CPU_WR, 16'h8001, 8'h81);
        add_op(ACT_CPU_RD, 16'h9FFF, 8'h00);
        add_op(ACT_CPU_RD, 16'hA000, 8'h00);
        add_op(ACT_CPU_RD, 16'hC000, 8'h00);
        add_op(ACT_CPU_RD, 16'hE001, 8'h00);
        add_op(ACT_PPU_RD, 16'h0C00, 8'h00);
        add_op(ACT_CPU_WR, 16'hA000, 8'h00);
        add_op(ACT_CPU_WR, 16'hA001, 8'h01);
        add_op(ACT_CPU_WR, 16'h7FFF, 8'hFF);
        add_op(ACT_CPU_WR, 16'hC000, 8'h01);
        add_op(ACT_CPU_WR, 16'hC001, 8'h00);
        add_op(ACT_CPU_WR, 16'hE001, 8'h00);
        add_op(ACT_TICK, 16'h0000, 8'h00);
        add_op(ACT_TICK, 16'hFFFF, 8'hFF);
        add_op(ACT_CPU_WR, 16'hE000, 8'h00);
        add_op(t_action'(ACT_TICK + 3'd3), 16'hFFFF, 8'hFF);
        gen_traffic(150);

        run_phase(510, 2040, 1, 180);
        run_phase(2, 0, 2, 180);
        run_phase(0, 1, 3, 180);
        run_phase(1, 2040, 0, 180);
        run_phase(37, 0, 1, 180);
        run_phase($urandom_range(2, 510), $urandom_range(0, 2040), 2, 180);
        run_phase(256, 256, 3, 180);
        run_phase(3, 7, 0, 180);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mapped_q.size() != 0) begin
            $error("%0d expected results never arrived", mapped_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
